// ===== src/kts_pkg.sv =====
// shared types and constants for the keyed timestamp set
`default_nettype none

package kts_pkg;

  // width of a stored timestamp
  localparam int TIME_BITS = 32;

  // item operation codes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // engine sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_RESP
  } state_t;

  // one result item handed from the engine to the output register
  typedef struct packed {
    logic                 found;
    logic [TIME_BITS-1:0] time_out;
    logic                 full_res;
  } res_t;

endpackage

`default_nettype wire

// ===== src/kts_ram.sv =====
// entry memory: one write port, one read port, registered read data
`default_nettype none

module kts_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 97,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/kts_engine.sv =====
// search and update sequencer: clears the table, scans it per item, writes back
`default_nettype none

module kts_engine #(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 64,
  parameter int AW       = 6,
  parameter int WIDTH    = 97
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // item transfer
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 opcode,
  input  wire logic [KEY_BITS-1:0]  key,
  input  wire logic [kts_pkg::TIME_BITS-1:0] time_in,
  // result transfer towards the output register
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output kts_pkg::res_t             res,
  // memory port
  output logic                      we,
  output logic      [AW-1:0]        waddr,
  output logic      [WIDTH-1:0]     wdata,
  output logic                      re,
  output logic      [AW-1:0]        raddr,
  input  wire logic [WIDTH-1:0]     rdata
);

  localparam int TB = kts_pkg::TIME_BITS;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  kts_pkg::state_t state, state_next;

  logic [AW-1:0]       cnt;
  logic                pend;
  logic [AW-1:0]       pend_idx;
  kts_pkg::op_t        op;
  logic [KEY_BITS-1:0] k;
  logic [TB-1:0]       t;
  logic                hit_f;
  logic [AW-1:0]       hit_idx;
  logic [TB-1:0]       hit_time;
  logic                free_f;
  logic [AW-1:0]       free_idx;

  // fields of the entry read back
  logic                rd_valid;
  logic [KEY_BITS-1:0] rd_key;
  logic [TB-1:0]       rd_time;
  logic                rd_match;

  assign rd_valid = rdata[WIDTH-1];
  assign rd_key   = rdata[TB +: KEY_BITS];
  assign rd_time  = rdata[TB-1:0];
  assign rd_match = rd_valid && (rd_key == k);

  // write-back decision
  logic          ins_new;
  logic          rem_hit;

  assign ins_new = (op == kts_pkg::OP_INSERT) && !hit_f && free_f;
  assign rem_hit = (op == kts_pkg::OP_REMOVE) && hit_f;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kts_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    we         = 1'b0;
    waddr      = cnt;
    wdata      = '0;
    re         = 1'b0;
    raddr      = cnt;
    case (state)
      kts_pkg::ST_CLEAR: begin
        we = 1'b1;
        if (cnt == LAST) begin
          state_next = kts_pkg::ST_IDLE;
        end
      end
      kts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = kts_pkg::ST_SCAN;
        end
      end
      kts_pkg::ST_SCAN: begin
        re = 1'b1;
        if (cnt == LAST) begin
          state_next = kts_pkg::ST_DRAIN;
        end
      end
      kts_pkg::ST_DRAIN: begin
        state_next = kts_pkg::ST_UPDATE;
      end
      kts_pkg::ST_UPDATE: begin
        if (ins_new) begin
          we    = 1'b1;
          waddr = free_idx;
          wdata = {1'b1, k, t};
        end else if (rem_hit) begin
          we    = 1'b1;
          waddr = hit_idx;
          wdata = {1'b0, k, t};
        end
        state_next = kts_pkg::ST_RESP;
      end
      kts_pkg::ST_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = kts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kts_pkg::ST_CLEAR;
      end
    endcase
  end

  // sweep counter for clearing and scanning
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == kts_pkg::ST_CLEAR || state == kts_pkg::ST_SCAN) begin
      cnt <= (cnt == LAST) ? '0 : cnt + AW'(1);
    end else begin
      cnt <= '0;
    end
  end

  // read in flight, its data is checked in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= (state == kts_pkg::ST_SCAN);
    end
    pend_idx <= cnt;
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op <= kts_pkg::op_t'(opcode);
      k  <= key;
      t  <= time_in;
    end
  end

  // first match and lowest free entry found by the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_f  <= 1'b0;
      free_f <= 1'b0;
    end else if (in_valid && in_ready) begin
      hit_f  <= 1'b0;
      free_f <= 1'b0;
    end else if (pend) begin
      if (rd_match && !hit_f) begin
        hit_f <= 1'b1;
      end
      if (!rd_valid && !free_f) begin
        free_f <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend && rd_match && !hit_f) begin
      hit_idx  <= pend_idx;
      hit_time <= rd_time;
    end
    if (pend && !rd_valid && !free_f) begin
      free_idx <= pend_idx;
    end
  end

  // result fields
  always_comb begin
    res.found    = hit_f;
    res.time_out = rem_hit ? hit_time : '0;
    res.full_res = (op == kts_pkg::OP_INSERT) && !hit_f && !free_f;
  end

endmodule

`default_nettype wire

// ===== src/keyed_timestamp_set_top.sv =====
// keyed timestamp set: entry table in memory, scanned once per item
// a new item is taken only after the result of the last one has gone to the
// output register; each item needs a full scan through the single read port
// of the entry memory
// reset: a clearing pass over all ENTRIES entries empties the table; no input
// transfer is taken until it ends. Writes and scans never overlap in time.
`default_nettype none

module keyed_timestamp_set_top #(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        opcode,
  input  wire logic [63:0] key,
  input  wire logic [31:0] time_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             found,
  output logic      [31:0] time_out,
  output logic             full_res
);

  localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WIDTH = 1 + KEY_BITS + kts_pkg::TIME_BITS;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [WIDTH-1:0] wdata;
  logic             re;
  logic [AW-1:0]    raddr;
  logic [WIDTH-1:0] rdata;

  logic             res_valid;
  logic             res_ready;
  kts_pkg::res_t    res;

  kts_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  kts_engine #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS),
    .AW       (AW),
    .WIDTH    (WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .key       (key[KEY_BITS-1:0]),
    .time_in   (time_in),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .re        (re),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  // output register, loads when empty or being drained
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      found    <= res.found;
      time_out <= res.time_out;
      full_res <= res.full_res;
    end
  end

endmodule

`default_nettype wire

// ===== tb/keyed_timestamp_set_top_test.sv =====
// testbench for the keyed timestamp set: directed table, then random traffic against a predictor
`default_nettype none

module keyed_timestamp_set_top_test;

  localparam int ENTRIES      = 64;
  localparam int KEY_BITS     = 64;
  localparam int RANDOM_ITEMS = 1400;
  localparam int POOL_KEYS    = 80;
  localparam int PHASE_ITEMS  = 120;
  localparam int HOLD_CYCLES  = 600;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DIRECTED     = 21;

  // one row of the directed table; expected result used only where typed is set
  typedef struct packed {
    kts_pkg::op_t  op;
    logic [63:0]   key;
    logic [31:0]   stamp;
    logic          typed;
    kts_pkg::res_t res;
  } stim_row_t;

  localparam kts_pkg::res_t RES_ZERO = '0;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        opcode;
  logic [63:0] key;
  logic [31:0] time_in;
  logic        out_valid;
  logic        out_ready;
  logic        found;
  logic [31:0] time_out;
  logic        full_res;

  // predicted contents of the entry table
  logic                slot_used [ENTRIES];
  logic [KEY_BITS-1:0] slot_key  [ENTRIES];
  logic [31:0]         slot_time [ENTRIES];

  kts_pkg::res_t lookup_results_due [$];
  logic [63:0]   key_pool [POOL_KEYS];
  stim_row_t     directed_rows [DIRECTED];
  int            mismatches;
  int            cycle_count;
  int            burst_left;
  bit            hold_req;

  keyed_timestamp_set_top #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .key       (key),
    .time_in   (time_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .time_out  (time_out),
    .full_res  (full_res)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // apply one item to the predicted table and return its result
  function automatic kts_pkg::res_t apply_to_table(kts_pkg::op_t op, logic [63:0] k_raw,
                                                   logic [31:0] stamp);
    logic [KEY_BITS-1:0] k;
    int   hit;
    int   free_slot;
    kts_pkg::res_t r;
    k = k_raw[KEY_BITS-1:0];
    hit = -1;
    free_slot = -1;
    r = RES_ZERO;
    // descending scan leaves the lowest matching and lowest free slot
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == k) hit = i;
      if (!slot_used[i]) free_slot = i;
    end
    if (op == kts_pkg::OP_INSERT) begin
      if (hit >= 0) begin
        r.found = 1'b1;
      end else if (free_slot >= 0) begin
        slot_used[free_slot] = 1'b1;
        slot_key[free_slot]  = k;
        slot_time[free_slot] = stamp;
      end else begin
        r.full_res = 1'b1;
      end
    end else if (hit >= 0) begin
      r.found    = 1'b1;
      r.time_out = slot_time[hit];
      slot_used[hit] = 1'b0;
    end
    return r;
  endfunction

  // offer one item and hold it until the transfer
  task automatic offer_item(input kts_pkg::op_t op, input logic [63:0] k,
                            input logic [31:0] stamp, input logic typed,
                            input kts_pkg::res_t typed_res);
    kts_pkg::res_t predicted;
    in_valid <= 1'b1;
    opcode   <= op;
    key      <= k;
    time_in  <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_to_table(op, k, stamp);
    lookup_results_due.push_back(typed ? typed_res : predicted);
  endtask

  // sender bursts with random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 15);
      burst_left = $urandom_range(0, 24);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // cycle counter and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("keyed_timestamp_set_top test failed");
    $finish;
  end

  // receiver: own stall pattern, plus one long hold-off to back the block up
  initial begin
    int mode;
    int mode_left;
    mode_left = 0;
    mode = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_ready <= ($urandom_range(0, 7) == 0);
          end
        endcase
      end
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    kts_pkg::res_t due;
    if (!rst && out_valid && out_ready) begin
      if (lookup_results_due.size() == 0) begin
        $display("%0t: unexpected result found=%0d time_out=%h full_res=%0d",
                 $time, found, time_out, full_res);
        mismatches++;
      end else begin
        due = lookup_results_due.pop_front();
        if (found !== due.found) begin
          $display("%0t: found expected %0d actual %0d", $time, due.found, found);
          mismatches++;
        end
        if (time_out !== due.time_out) begin
          $display("%0t: time_out expected %h actual %h", $time, due.time_out, time_out);
          mismatches++;
        end
        if (full_res !== due.full_res) begin
          $display("%0t: full_res expected %0d actual %0d", $time, due.full_res, full_res);
          mismatches++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int           phase;
    int           insert_weight [6];
    kts_pkg::op_t op;
    logic [63:0]  k;

    insert_weight = '{95, 50, 10, 85, 50, 30};
    mismatches  = 0;
    cycle_count = 0;
    burst_left  = 0;
    hold_req    = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
      slot_time[i] = '0;
    end
    for (int i = 0; i < POOL_KEYS; i++) begin
      key_pool[i] = {$urandom, $urandom};
    end

    directed_rows = '{
      // empty table after reset, extreme keys absent
      '{kts_pkg::OP_REMOVE, 64'h0, 32'h0, 1'b1, RES_ZERO},
      '{kts_pkg::OP_REMOVE, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 1'b1, RES_ZERO},
      '{kts_pkg::OP_INSERT, 64'h0, 32'h0, 1'b1, RES_ZERO},
      '{kts_pkg::OP_INSERT, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 1'b1, RES_ZERO},
      // duplicate inserts keep the stored time
      '{kts_pkg::OP_INSERT, 64'hffff_ffff_ffff_ffff, 32'h0000_1234, 1'b1,
        '{found: 1'b1, time_out: 32'h0, full_res: 1'b0}},
      '{kts_pkg::OP_INSERT, 64'h0, 32'hffff_ffff, 1'b1,
        '{found: 1'b1, time_out: 32'h0, full_res: 1'b0}},
      '{kts_pkg::OP_REMOVE, 64'hffff_ffff_ffff_ffff, 32'h0, 1'b1,
        '{found: 1'b1, time_out: 32'hffff_ffff, full_res: 1'b0}},
      // second remove of the same key finds nothing
      '{kts_pkg::OP_REMOVE, 64'hffff_ffff_ffff_ffff, 32'h0, 1'b1, RES_ZERO},
      '{kts_pkg::OP_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000, 1'b0, RES_ZERO},
      '{kts_pkg::OP_INSERT, 64'h0000_0000_0000_0001, 32'h0000_0001, 1'b0, RES_ZERO},
      '{kts_pkg::OP_INSERT, 64'h5555_5555_5555_5555, 32'haaaa_aaaa, 1'b0, RES_ZERO},
      '{kts_pkg::OP_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 32'h5555_5555, 1'b0, RES_ZERO},
      '{kts_pkg::OP_REMOVE, 64'h5555_5555_5555_5555, 32'hffff_ffff, 1'b0, RES_ZERO},
      '{kts_pkg::OP_INSERT, 64'h4142_4344_4546_4748, 32'h0000_0007, 1'b0, RES_ZERO},
      '{kts_pkg::OP_REMOVE, 64'h0, 32'h0, 1'b1,
        '{found: 1'b1, time_out: 32'h0, full_res: 1'b0}},
      '{kts_pkg::OP_REMOVE, 64'h8000_0000_0000_0000, 32'h0, 1'b0, RES_ZERO},
      '{kts_pkg::OP_REMOVE, 64'haaaa_aaaa_aaaa_aaaa, 32'h0, 1'b0, RES_ZERO},
      // freed slots are reused
      '{kts_pkg::OP_INSERT, 64'h5555_5555_5555_5555, 32'h1357_9bdf, 1'b0, RES_ZERO},
      '{kts_pkg::OP_REMOVE, 64'h0000_0000_0000_0001, 32'h0, 1'b0, RES_ZERO},
      '{kts_pkg::OP_REMOVE, 64'h4142_4344_4546_4748, 32'h0, 1'b0, RES_ZERO},
      '{kts_pkg::OP_REMOVE, 64'h5555_5555_5555_5555, 32'h0, 1'b0, RES_ZERO}
    };

    // inputs known from the start, reset held before the directed table
    rst      <= 1'b1;
    in_valid <= 1'b0;
    opcode   <= kts_pkg::OP_INSERT;
    key      <= '0;
    time_in  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIRECTED; i++) begin
      offer_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].stamp,
                 directed_rows[i].typed, directed_rows[i].res);
      pace_sender();
    end

    // random traffic: phases lean towards filling or emptying the table
    hold_req = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n / PHASE_ITEMS) % 6;
      op = ($urandom_range(0, 99) < insert_weight[phase]) ? kts_pkg::OP_INSERT
                                                          : kts_pkg::OP_REMOVE;
      if ($urandom_range(0, 9) == 0) begin
        k = {$urandom, $urandom};
      end else begin
        k = key_pool[$urandom_range(0, POOL_KEYS - 1)];
      end
      offer_item(op, k, $urandom, 1'b0, RES_ZERO);
      pace_sender();
    end

    // drain and settle
    in_valid <= 1'b0;
    while (lookup_results_due.size() != 0) @(posedge clk);
    repeat (ENTRIES + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("keyed_timestamp_set_top test passed");
    end else begin
      $display("keyed_timestamp_set_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
